### sv/tbd_pkg.sv
// Package for the two-band beat detector: widths, fixed-point coefficients,
// sequencer state type and the result record shared by all design files.
// No dependencies.
package tbd_pkg;

  // Level format is unsigned Q0.LEVEL_BITS
  localparam int LEVEL_BITS = 15;
  localparam int RUN_LIMIT  = 64;

  localparam int FRAC      = 16;
  localparam int SHARE_W   = 17;
  localparam int K_W       = 17;
  localparam int CNT_W     = 8;
  localparam int MUL_A_W   = (LEVEL_BITS > SHARE_W) ? LEVEL_BITS : SHARE_W;
  localparam int ACC_W     = MUL_A_W + K_W + 1;

  typedef logic [LEVEL_BITS-1:0]   level_t;
  typedef logic [SHARE_W-1:0]      share_t;
  typedef logic [K_W-1:0]          coef_t;
  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic [MUL_A_W-1:0]      mul_a_t;
  typedef logic [ACC_W-1:0]        acc_t;

  // Q1.16 coefficients
  localparam coef_t K_SMOOTH_OLD = coef_t'(45875);
  localparam coef_t K_SMOOTH_NEW = coef_t'(19661);
  localparam coef_t K_AVG_OLD    = coef_t'(64783);
  localparam coef_t K_AVG_NEW    = coef_t'(753);
  localparam coef_t K_UP         = coef_t'(66191);
  localparam coef_t K_DOWN       = coef_t'(64881);
  localparam coef_t ONE_Q16      = coef_t'(65536);
  localparam share_t SHARE_MIN   = share_t'(6554);
  localparam share_t SHARE_MAX   = share_t'(64225);
  localparam acc_t HALF_Q16      = acc_t'(32768);

  localparam level_t PEAK_FLOOR  = level_t'(((64'd1 << LEVEL_BITS) + 64'd5) / 64'd10);

  localparam cnt_t RUN_MAX       = cnt_t'(RUN_LIMIT);
  localparam cnt_t RUN_MIN       = cnt_t'(-RUN_LIMIT);
  localparam cnt_t LONG_RUN      = cnt_t'(10);
  localparam cnt_t NEG_LONG_RUN  = cnt_t'(-10);
  localparam cnt_t BEAT_COUNT    = cnt_t'(3);
  localparam cnt_t SUSTAIN_END   = cnt_t'(20);
  localparam cnt_t CNT_ZERO      = cnt_t'(0);
  localparam cnt_t CNT_ONE       = cnt_t'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_OLD,
    ST_SM_NEW,
    ST_AVG_OLD,
    ST_AVG_NEW,
    ST_PEAK,
    ST_THR_PEAK,
    ST_THR_AVG,
    ST_DECIDE,
    ST_SHARE,
    ST_DECAY_OLD,
    ST_DECAY_NEW,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic   beat_low;
    logic   beat_high;
    logic   both_sustained;
    level_t strength_low;
    level_t strength_high;
  } result_t;

endpackage

### sv/tbd_if.sv
// Valid/ready channel interfaces for the beat detector input and result.
// Depends on tbd_pkg for the level width.
interface tbd_in_if;
  logic                 valid;
  logic                 ready;
  tbd_pkg::level_t      low_band_level;
  tbd_pkg::level_t      high_band_level;

  modport source(output valid, output low_band_level, output high_band_level, input ready);
  modport sink(input valid, input low_band_level, input high_band_level, output ready);
endinterface

interface tbd_out_if;
  logic                 valid;
  logic                 ready;
  logic                 beat_low;
  logic                 beat_high;
  logic                 both_sustained;
  tbd_pkg::level_t      strength_low;
  tbd_pkg::level_t      strength_high;

  modport source(output valid, output beat_low, output beat_high, output both_sustained,
                 output strength_low, output strength_high, input ready);
  modport sink(input valid, input beat_low, input beat_high, input both_sustained,
               input strength_low, input strength_high, output ready);
endinterface

### sv/tbd_mac.sv
// Shared multiply-accumulate unit: one product per cycle, while en or clr is set, into a registered
// accumulator. Depends on tbd_pkg.
module tbd_mac (
  input  logic            clk,
  input  logic            en,
  input  logic            clr,
  input  tbd_pkg::mul_a_t op_a,
  input  tbd_pkg::coef_t  op_b,
  output tbd_pkg::acc_t   acc
);

  logic [tbd_pkg::MUL_A_W+tbd_pkg::K_W-1:0] prod;
  tbd_pkg::acc_t acc_r;
  tbd_pkg::acc_t acc_nxt;

  assign prod = op_a * op_b;

  always_comb begin
    if (clr) begin
      acc_nxt = tbd_pkg::ACC_W'(prod);
    end else begin
      acc_nxt = acc_r + tbd_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (en || clr) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

### sv/tbd_seq.sv
// Per-frame sequencer: holds both bands' tracking state and walks each band
// through its update using the shared MAC. Depends on tbd_pkg and tbd_mac.
module tbd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tbd_pkg::level_t   lvl_low,
  input  tbd_pkg::level_t   lvl_high,
  input  logic              out_free,
  output logic              idle,
  output logic              done,
  output tbd_pkg::result_t  res
);

  tbd_pkg::seq_state_t state_r, state_nxt;
  logic                band_r, band_nxt;
  logic                up_r, up_nxt;
  logic                down_r, down_nxt;
  tbd_pkg::level_t     lvl_low_r, lvl_high_r;

  tbd_pkg::level_t     sm_r    [2];
  tbd_pkg::level_t     avg_r   [2];
  tbd_pkg::level_t     peak_r  [2];
  tbd_pkg::level_t     cand_r  [2];
  tbd_pkg::share_t     share_r [2];
  tbd_pkg::cnt_t       cnt_r   [2];

  tbd_pkg::level_t     sm_nxt, avg_nxt, peak_nxt, cand_nxt;
  tbd_pkg::share_t     share_nxt;
  tbd_pkg::cnt_t       cnt_nxt;

  tbd_pkg::level_t     sm_cur, avg_cur, peak_cur, cand_cur, lvl_cur;
  tbd_pkg::share_t     share_cur;
  tbd_pkg::cnt_t       cnt_cur;

  logic                mac_en, mac_clr;
  tbd_pkg::mul_a_t     op_a;
  tbd_pkg::coef_t      op_b;
  tbd_pkg::acc_t       mac_acc;
  tbd_pkg::acc_t       rnd_sum;
  tbd_pkg::level_t     rnd_lvl;
  tbd_pkg::share_t     rnd_share;
  tbd_pkg::acc_t       sm_ext;

  tbd_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .clr  (mac_clr),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (mac_acc)
  );

  assign sm_cur    = sm_r[band_r];
  assign avg_cur   = avg_r[band_r];
  assign peak_cur  = peak_r[band_r];
  assign cand_cur  = cand_r[band_r];
  assign share_cur = share_r[band_r];
  assign cnt_cur   = cnt_r[band_r];
  assign lvl_cur   = band_r ? lvl_high_r : lvl_low_r;

  // round half up out of Q.16
  assign rnd_sum   = mac_acc + tbd_pkg::HALF_Q16;
  assign rnd_lvl   = rnd_sum[tbd_pkg::FRAC +: tbd_pkg::LEVEL_BITS];
  assign rnd_share = rnd_sum[tbd_pkg::FRAC +: tbd_pkg::SHARE_W];
  assign sm_ext    = tbd_pkg::ACC_W'({sm_cur, {tbd_pkg::FRAC{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbd_pkg::ST_IDLE;
      band_r  <= 1'b0;
      up_r    <= 1'b0;
      down_r  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        sm_r[i]    <= '0;
        avg_r[i]   <= '0;
        peak_r[i]  <= '0;
        cand_r[i]  <= '0;
        share_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else begin
      state_r         <= state_nxt;
      band_r          <= band_nxt;
      up_r            <= up_nxt;
      down_r          <= down_nxt;
      sm_r[band_r]    <= sm_nxt;
      avg_r[band_r]   <= avg_nxt;
      peak_r[band_r]  <= peak_nxt;
      cand_r[band_r]  <= cand_nxt;
      share_r[band_r] <= share_nxt;
      cnt_r[band_r]   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lvl_low_r  <= lvl_low;
      lvl_high_r <= lvl_high;
    end
  end

  always_comb begin
    tbd_pkg::cnt_t   c0;
    tbd_pkg::cnt_t   c2;
    tbd_pkg::level_t cand0;
    tbd_pkg::level_t pk1;
    logic            above;

    state_nxt = state_r;
    band_nxt  = band_r;
    up_nxt    = up_r;
    down_nxt  = down_r;
    sm_nxt    = sm_cur;
    avg_nxt   = avg_cur;
    peak_nxt  = peak_cur;
    cand_nxt  = cand_cur;
    share_nxt = share_cur;
    cnt_nxt   = cnt_cur;
    mac_en    = 1'b0;
    mac_clr   = 1'b0;
    op_a      = '0;
    op_b      = '0;
    done      = 1'b0;
    c0        = cnt_cur;
    c2        = cnt_cur;
    cand0     = cand_cur;
    pk1       = peak_cur;
    above     = sm_ext > mac_acc;

    case (state_r)
      tbd_pkg::ST_IDLE: begin
        if (start) begin
          band_nxt  = 1'b0;
          state_nxt = tbd_pkg::ST_SM_OLD;
        end
      end
      tbd_pkg::ST_SM_OLD: begin
        mac_clr   = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(sm_cur);
        op_b      = tbd_pkg::K_SMOOTH_OLD;
        state_nxt = tbd_pkg::ST_SM_NEW;
      end
      tbd_pkg::ST_SM_NEW: begin
        mac_en    = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(lvl_cur);
        op_b      = tbd_pkg::K_SMOOTH_NEW;
        state_nxt = tbd_pkg::ST_AVG_OLD;
      end
      tbd_pkg::ST_AVG_OLD: begin
        sm_nxt    = rnd_lvl;
        mac_clr   = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(avg_cur);
        op_b      = tbd_pkg::K_AVG_OLD;
        state_nxt = tbd_pkg::ST_AVG_NEW;
      end
      tbd_pkg::ST_AVG_NEW: begin
        mac_en    = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(sm_cur);
        op_b      = tbd_pkg::K_AVG_NEW;
        state_nxt = tbd_pkg::ST_PEAK;
      end
      tbd_pkg::ST_PEAK: begin
        avg_nxt  = rnd_lvl;
        pk1      = (peak_cur > tbd_pkg::PEAK_FLOOR) ? peak_cur : tbd_pkg::PEAK_FLOOR;
        peak_nxt = (pk1 > rnd_lvl) ? pk1 : rnd_lvl;
        if (share_cur < tbd_pkg::SHARE_MIN) begin
          share_nxt = tbd_pkg::SHARE_MIN;
        end else if (share_cur > tbd_pkg::SHARE_MAX) begin
          share_nxt = tbd_pkg::SHARE_MAX;
        end
        state_nxt = tbd_pkg::ST_THR_PEAK;
      end
      tbd_pkg::ST_THR_PEAK: begin
        mac_clr   = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(peak_cur);
        op_b      = tbd_pkg::K_W'(share_cur);
        state_nxt = tbd_pkg::ST_THR_AVG;
      end
      tbd_pkg::ST_THR_AVG: begin
        mac_en    = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(avg_cur);
        op_b      = tbd_pkg::ONE_Q16 - tbd_pkg::K_W'(share_cur);
        state_nxt = tbd_pkg::ST_DECIDE;
      end
      tbd_pkg::ST_DECIDE: begin
        // accumulator holds peak*share + avg*(1-share), exact
        up_nxt   = 1'b0;
        down_nxt = 1'b0;
        if (above) begin
          if (cnt_cur <= tbd_pkg::CNT_ZERO) begin
            cnt_nxt  = tbd_pkg::CNT_ONE;
            cand_nxt = sm_cur;
          end else begin
            c2      = (cnt_cur < tbd_pkg::RUN_MAX) ? cnt_cur + tbd_pkg::CNT_ONE : cnt_cur;
            cnt_nxt = c2;
            if (c2 > tbd_pkg::LONG_RUN) begin
              if (cand_cur > peak_cur) begin
                peak_nxt = cand_cur;
              end else begin
                up_nxt = 1'b1;
              end
            end
            cand_nxt = (cand_cur > sm_cur) ? cand_cur : sm_cur;
          end
        end else begin
          if (cnt_cur > tbd_pkg::CNT_ZERO) begin
            peak_nxt = cand_cur;
            c0       = tbd_pkg::CNT_ZERO;
            cand0    = sm_cur;
          end
          cand_nxt = (cand0 > sm_cur) ? cand0 : sm_cur;
          c2       = (c0 > tbd_pkg::RUN_MIN) ? c0 - tbd_pkg::CNT_ONE : c0;
          cnt_nxt  = c2;
          if (c2 < tbd_pkg::NEG_LONG_RUN) begin
            down_nxt = 1'b1;
          end
        end
        mac_clr   = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(share_cur);
        op_b      = above ? tbd_pkg::K_UP : tbd_pkg::K_DOWN;
        state_nxt = tbd_pkg::ST_SHARE;
      end
      tbd_pkg::ST_SHARE: begin
        if (up_r || down_r) begin
          share_nxt = rnd_share;
        end
        mac_clr   = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(peak_cur);
        op_b      = tbd_pkg::K_AVG_OLD;
        state_nxt = tbd_pkg::ST_DECAY_OLD;
      end
      tbd_pkg::ST_DECAY_OLD: begin
        mac_en    = 1'b1;
        op_a      = tbd_pkg::MUL_A_W'(cand_cur);
        op_b      = tbd_pkg::K_AVG_NEW;
        state_nxt = tbd_pkg::ST_DECAY_NEW;
      end
      tbd_pkg::ST_DECAY_NEW: begin
        if (down_r) begin
          peak_nxt = rnd_lvl;
        end
        if (!band_r) begin
          band_nxt  = 1'b1;
          state_nxt = tbd_pkg::ST_SM_OLD;
        end else begin
          state_nxt = tbd_pkg::ST_DONE;
        end
      end
      tbd_pkg::ST_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          band_nxt  = 1'b0;
          state_nxt = tbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tbd_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle = (state_r == tbd_pkg::ST_IDLE);

  // frame result from the final per-band state
  always_comb begin
    logic sus_low;
    logic sus_high;

    sus_low  = (cnt_r[0] >= tbd_pkg::BEAT_COUNT) && (cnt_r[0] < tbd_pkg::SUSTAIN_END);
    sus_high = (cnt_r[1] >= tbd_pkg::BEAT_COUNT) && (cnt_r[1] < tbd_pkg::SUSTAIN_END);
    res.beat_low       = (cnt_r[0] == tbd_pkg::BEAT_COUNT);
    res.beat_high      = (cnt_r[1] == tbd_pkg::BEAT_COUNT);
    res.both_sustained = (res.beat_low || res.beat_high) && sus_low && sus_high;
    res.strength_low   = res.beat_low ? cand_r[0] : '0;
    res.strength_high  = res.beat_high ? cand_r[1] : '0;
  end

endmodule

### sv/two_band_beat_detector_core.sv
// Each frame runs 11 sequencer steps per band on one shared multiply-accumulate
// unit, then hands the result off to the output register.
// Frames are taken one at a time, only while the sequencer is idle; the
// next frame is taken while a finished result waits in the output register.
// Reset: synchronous, active low; clears all band state to zero and both channels idle.
module two_band_beat_detector_core (
  input  logic           clk,
  input  logic           rst_n,
  tbd_in_if.sink         in_ch,
  tbd_out_if.source      out_ch
);

  logic             seq_idle;
  logic             seq_done;
  logic             out_free;
  logic             in_take;
  tbd_pkg::result_t seq_res;
  tbd_pkg::result_t out_data_r;
  logic             out_valid_r;

  assign in_ch.ready = seq_idle;
  assign in_take     = in_ch.valid && seq_idle;
  assign out_free    = !out_valid_r || out_ch.ready;

  tbd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_take),
    .lvl_low  (in_ch.low_band_level),
    .lvl_high (in_ch.high_band_level),
    .out_free (out_free),
    .idle     (seq_idle),
    .done     (seq_done),
    .res      (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_data_r <= seq_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.beat_low       = out_data_r.beat_low;
  assign out_ch.beat_high      = out_data_r.beat_high;
  assign out_ch.both_sustained = out_data_r.both_sustained;
  assign out_ch.strength_low   = out_data_r.strength_low;
  assign out_ch.strength_high  = out_data_r.strength_high;

endmodule

### sv/tbd_checker.sv
// Port-level checks for the beat detector core, attached by bind.
// Depends on tbd_pkg, tbd_if and two_band_beat_detector_core.
module tbd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            beat_low,
  input logic            beat_high,
  input logic            both_sustained,
  input tbd_pkg::level_t strength_low,
  input tbd_pkg::level_t strength_high
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(beat_low) && $stable(beat_high)
      && $stable(both_sustained) && $stable(strength_low) && $stable(strength_high))
    else $error("stalled result changed");

  // a frame in work blocks the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // a new result is posted as the sequencer goes idle
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while frame still in work");

  a_strength_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (beat_low || strength_low == '0) && (beat_high || strength_high == '0))
    else $error("strength without beat");

  a_sustain_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && both_sustained |-> beat_low || beat_high)
    else $error("sustained flag without beat");

endmodule

bind two_band_beat_detector_core tbd_checker u_tbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .beat_low       (out_ch.beat_low),
  .beat_high      (out_ch.beat_high),
  .both_sustained (out_ch.both_sustained),
  .strength_low   (out_ch.strength_low),
  .strength_high  (out_ch.strength_high)
);
